FILE: rtl/core/pil_pkg.sv
`default_nettype none

package pil_pkg;

    // Number of cells in the row.
    localparam int LIST_DEPTH = 16;

    // Field widths fixed by the interface.
    localparam int POS_W   = 8;
    localparam int VAL_W   = 32;
    localparam int OCNT_W  = 9;
    localparam int IDX_W   = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W   = $clog2(LIST_DEPTH + 1);

    // Command codes.
    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_READ   = 1'b1
    } t_cmd;

    // Status codes.
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BEYOND = 2'd1,
        ST_FULL   = 2'd2,
        ST_RANGE  = 2'd3
    } t_status;

    // Input beat.
    typedef struct packed {
        t_cmd                     command;
        logic signed [VAL_W-1:0]  value;
        logic [POS_W-1:0]         position;
    } t_in_beat;

    // Result beat.
    typedef struct packed {
        t_status                  status;
        logic signed [VAL_W-1:0]  read_value;
        logic [OCNT_W-1:0]        element_count;
        logic signed [VAL_W-1:0]  element_sum;
    } t_out_beat;

    // Control broadcast from the controller to every cell.
    typedef struct packed {
        logic                     insert_en;
        logic [POS_W-1:0]         position;
        logic [VAL_W-1:0]         value;
    } t_cell_ctl;

endpackage

`default_nettype wire

FILE: rtl/core/positional_insert_list.sv
// Channel   Direction  Ports                                  Beat type
// input     in         i_in_valid, o_in_stall, i_in_data      t_in_beat
// output    out        o_out_valid, i_out_stall, o_out_data   t_out_beat
//
// On the edge that accepts a beat, the row of cells shifts or loads and
// the result lands in the output register.
// One beat per cycle is sustained while the output side does not stall.
// A stalled result holds the output register, and the input stalls with it.
// Reset (synchronous, active low) empties the list and clears the sum; the
// cell contents are not cleared, since only cells below the count are read.
`default_nettype none

module positional_insert_list
    import pil_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_beat  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_beat      o_out_data
);

    logic                 w_accept;
    t_cell_ctl            w_ctl;
    t_out_beat            w_res;
    t_out_beat            w_beat;
    logic [VAL_W-1:0]     w_cell_val [LIST_DEPTH];
    logic [VAL_W-1:0]     w_read;
    logic                 r_out_valid;
    logic                 n_out_valid;
    t_out_beat            r_out_data;

    // Input is held off only while a result waits and the sink stalls.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    pil_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_beat   (i_in_data),
        .o_ctl    (w_ctl),
        .o_res    (w_res)
    );

    // Row of cells; each one takes its front neighbor's value on a shift.
    for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_head
            pil_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_index (POS_W'(g)),
                .i_prev  (w_ctl.value),
                .o_val   (w_cell_val[g])
            );
        end else begin : g_body
            pil_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_index (POS_W'(g)),
                .i_prev  (w_cell_val[g-1]),
                .o_val   (w_cell_val[g])
            );
        end
    end

    // Read select; only meaningful for an in-range read.
    assign w_read = w_cell_val[i_in_data.position[IDX_W-1:0]];

    always_comb begin
        w_beat = w_res;
        if ((i_in_data.command == CMD_READ) && (w_res.status == ST_OK)) begin
            w_beat.read_value = w_read;
        end
    end

    // Output register.
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_accept) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= w_beat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // The reported count never exceeds the number of cells.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.element_count <= OCNT_W'(LIST_DEPTH)))
        else $error("element count above list depth");

    // A rejected result carries a zero read value.
    a_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status != ST_OK)) |->
            (o_out_data.read_value == '0))
        else $error("read value not zero on a failed beat");

    // A read beat never reports an insert status.
    a_read_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in_data.command == CMD_READ)) |=>
            ((o_out_data.status == ST_OK) || (o_out_data.status == ST_RANGE)))
        else $error("read beat with insert status");

    // Every accepted beat produces a result on the next cycle.
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_out_valid)
        else $error("accepted beat produced no result");

endmodule

`default_nettype wire

FILE: rtl/core/pil_cell.sv
`default_nettype none

module pil_cell
    import pil_pkg::*;
(
    input  wire logic              i_clk,
    input  wire t_cell_ctl         i_ctl,
    input  wire logic [POS_W-1:0]  i_index,
    input  wire logic [VAL_W-1:0]  i_prev,
    output logic [VAL_W-1:0]       o_val
);

    logic [VAL_W-1:0] r_val;
    logic [VAL_W-1:0] n_val;

    // On an insert, the cell at the position loads the new value and every
    // cell behind it takes its front neighbor's value.
    always_comb begin
        n_val = r_val;
        if (i_ctl.insert_en) begin
            if (i_index == i_ctl.position) begin
                n_val = i_ctl.value;
            end else if (i_index > i_ctl.position) begin
                n_val = i_prev;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;

endmodule

`default_nettype wire

FILE: rtl/core/pil_ctrl.sv
`default_nettype none

module pil_ctrl
    import pil_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_accept,
    input  wire t_in_beat  i_beat,
    output t_cell_ctl      o_ctl,
    output t_out_beat      o_res
);

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [VAL_W-1:0]  r_sum;
    logic [VAL_W-1:0]  n_sum;
    logic [OCNT_W-1:0] w_pos_ext;
    logic [OCNT_W-1:0] w_cnt_ext;
    logic              w_full;
    logic              w_insert;
    t_status           w_status;

    assign w_pos_ext = {1'b0, i_beat.position};
    assign w_cnt_ext = OCNT_W'(r_count);
    assign w_full    = (r_count == CNT_W'(LIST_DEPTH));

    // Status of the beat; the position check comes before the full check.
    always_comb begin
        w_status = ST_OK;
        if (i_beat.command == CMD_INSERT) begin
            priority if (w_pos_ext > w_cnt_ext) begin
                w_status = ST_BEYOND;
            end else if (w_full) begin
                w_status = ST_FULL;
            end
        end else begin
            if (!(w_pos_ext < w_cnt_ext)) begin
                w_status = ST_RANGE;
            end
        end
    end

    assign w_insert = i_accept && (i_beat.command == CMD_INSERT) && (w_status == ST_OK);

    // Count and running sum after this beat.
    always_comb begin
        n_count = r_count;
        n_sum   = r_sum;
        if (w_insert) begin
            n_count = r_count + CNT_W'(1);
            n_sum   = r_sum + i_beat.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
        end else begin
            r_count <= n_count;
            r_sum   <= n_sum;
        end
    end

    // Broadcast to the cell row.
    assign o_ctl.insert_en = w_insert;
    assign o_ctl.position  = i_beat.position;
    assign o_ctl.value     = i_beat.value;

    // Result fields known here; the top level fills in the read value.
    assign o_res.status        = w_status;
    assign o_res.read_value    = '0;
    assign o_res.element_count = OCNT_W'(n_count);
    assign o_res.element_sum   = n_sum;

endmodule

`default_nettype wire

FILE: bench/positional_insert_list_test.sv
module positional_insert_list_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pil_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 10;
    localparam int MAX_REPORTS = 40;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_beat  in_data = '0;
    logic      out_stall = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_out_beat out_data;

    // Shadow copy of the list, its count and its running sum.
    logic signed [VAL_W-1:0] shadow_cells [LIST_DEPTH];
    int                      shadow_count = 0;
    logic signed [VAL_W-1:0] shadow_sum = '0;

    // Results still owed by the block, oldest first.
    t_out_beat list_replies [$];

    int mismatch_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    positional_insert_list dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always #10 i_clk = ~i_clk;

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Output side stalls at the rate of the current phase.
    always @(posedge i_clk) begin
        out_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
    end

    // Applies one command to the shadow list and returns the result it owes.
    function automatic t_out_beat apply_list_op(t_in_beat b);
        t_out_beat r;
        int        i;
        r = '0;
        r.status = ST_OK;
        if (b.command == CMD_INSERT) begin
            if (int'(b.position) > shadow_count) begin
                r.status = ST_BEYOND;
            end else if (shadow_count >= LIST_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                for (i = shadow_count; i > int'(b.position); i--) begin
                    shadow_cells[i] = shadow_cells[i-1];
                end
                shadow_cells[b.position[IDX_W-1:0]] = b.value;
                shadow_count++;
                shadow_sum = shadow_sum + b.value;
            end
        end else begin
            if (int'(b.position) < shadow_count) begin
                r.read_value = shadow_cells[b.position[IDX_W-1:0]];
            end else begin
                r.status = ST_RANGE;
            end
        end
        r.element_count = OCNT_W'(shadow_count);
        r.element_sum = shadow_sum;
        return r;
    endfunction

    function automatic t_in_beat make_beat(t_cmd c, logic [VAL_W-1:0] v, int p);
        t_in_beat b;
        b.command = c;
        b.value = v;
        b.position = POS_W'(p);
        return b;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        if (mismatch_count < MAX_REPORTS) begin
            $display("tb: mismatch in %s: got %0h, expected %0h", what, got, want);
        end
        mismatch_count++;
    endtask

    // Compare every accepted result beat against the oldest owed result.
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (list_replies.size() == 0) begin
                report_mismatch("unexpected beat", longint'(out_data.element_count),
                                longint'(0));
            end else begin
                want = list_replies.pop_front();
                if (out_data.status !== want.status)
                    report_mismatch("status", longint'(out_data.status),
                                    longint'(want.status));
                if (out_data.read_value !== want.read_value)
                    report_mismatch("read_value", longint'(out_data.read_value),
                                    longint'(want.read_value));
                if (out_data.element_count !== want.element_count)
                    report_mismatch("element_count", longint'(out_data.element_count),
                                    longint'(want.element_count));
                if (out_data.element_sum !== want.element_sum)
                    report_mismatch("element_sum", longint'(out_data.element_sum),
                                    longint'(want.element_sum));
            end
        end
    end

    // Sends one beat, idling first at the current rate. Valid stays high on return
    // so that back-to-back beats need no second assignment in one step.
    task automatic send_beat(t_in_beat b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= b;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        list_replies.push_back(apply_list_op(b));
    endtask

    // Holds the input idle until every owed result has come back.
    task automatic wait_for_replies();
        in_valid <= 1'b0;
        while (list_replies.size() != 0) @(posedge i_clk);
    endtask

    // Reads and inserts on an empty list are all rejected.
    task automatic test_empty_list();
        send_beat(make_beat(CMD_READ, 32'h1234_5678, 0));
        send_beat(make_beat(CMD_INSERT, 32'h0000_0001, 1));
        send_beat(make_beat(CMD_INSERT, 32'hFFFF_FFFF, 255));
    endtask

    // Inserts at the front, in the middle and at the end, with extreme values.
    task automatic test_insert_positions();
        send_beat(make_beat(CMD_INSERT, 32'h8000_0000, 0));
        send_beat(make_beat(CMD_INSERT, 32'h7FFF_FFFF, 1));
        send_beat(make_beat(CMD_INSERT, 32'hFFFF_FFFF, 1));
        send_beat(make_beat(CMD_INSERT, 32'h5555_5555, 0));
        send_beat(make_beat(CMD_INSERT, 32'hAAAA_AAAA, 4));
        send_beat(make_beat(CMD_INSERT, 32'h0000_0000, 2));
        send_beat(make_beat(CMD_INSERT, 32'h0000_0001, 8));
    endtask

    // Reads every held entry, then indexes at and far past the count.
    task automatic test_reads();
        int k;
        for (k = 0; k < shadow_count; k++) begin
            send_beat(make_beat(CMD_READ, $urandom, k));
        end
        send_beat(make_beat(CMD_READ, 32'h0, shadow_count));
        send_beat(make_beat(CMD_READ, 32'hFFFF_FFFF, 255));
    endtask

    // Tops the list up at random positions, then tries inserts on a full list and reads its last entry and one past it.
    task automatic test_full_list();
        while (shadow_count < LIST_DEPTH) begin
            send_beat(make_beat(CMD_INSERT, $urandom, $urandom_range(shadow_count)));
        end
        send_beat(make_beat(CMD_INSERT, $urandom, LIST_DEPTH));
        send_beat(make_beat(CMD_INSERT, $urandom, 0));
        send_beat(make_beat(CMD_INSERT, $urandom, LIST_DEPTH + 1));
        send_beat(make_beat(CMD_INSERT, $urandom, 255));
        send_beat(make_beat(CMD_READ, $urandom, LIST_DEPTH - 1));
        send_beat(make_beat(CMD_READ, $urandom, LIST_DEPTH));
    endtask

    // Random mix: mostly valid positions, some anywhere in the field's range.
    task automatic test_random_mix(int beats);
        int k;
        int p;
        t_cmd c;
        for (k = 0; k < beats; k++) begin
            c = ($urandom_range(99) < 40) ? CMD_INSERT : CMD_READ;
            if ($urandom_range(99) < 80) begin
                if (c == CMD_INSERT)
                    p = $urandom_range(shadow_count);
                else
                    p = (shadow_count > 0) ? $urandom_range(shadow_count - 1) : 0;
            end else begin
                p = $urandom_range(255);
            end
            send_beat(make_beat(c, $urandom, p));
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Sender mostly busy, receiver mostly stalled.
        send_idle_pct = 13;
        recv_idle_pct = 75;
        test_empty_list();
        test_insert_positions();
        test_reads();
        test_random_mix(410);
        test_full_list();

        // Let everything owed come back before the next phase.
        wait_for_replies();

        // Sender mostly idle, receiver mostly ready.
        send_idle_pct = 75;
        recv_idle_pct = 13;
        test_random_mix(420);

        // Full rate in both directions.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_mix(420);

        wait_for_replies();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
